>>> src/aarm_pkg.sv
// aarm_pkg: shared types and constants for the axis-angle rotation matrix unit
// no dependencies

package aarm_pkg;

	localparam int TBL_LEN = 32;

	// cordic arctangent table, 32-bit binary angle units
	localparam logic [31:0] ATAN_TAB [TBL_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	// squared norm is below 2^34, scaled up to 62 bits for the root
	localparam int SUM_W  = 35;
	localparam int ROOT_W = 31;
	localparam int QUO_W  = 32;

	typedef logic signed [31:0] q30_t;

endpackage

>>> src/aarm_cordic.sv
// aarm_cordic: pipelined rotation-mode cordic, sine and cosine in q.30
// depends on aarm_pkg

module aarm_cordic import aarm_pkg::*; #(
	parameter int STAGES = 16,
	parameter int LAT    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [15:0] angle,
	output logic        out_vld,
	output q30_t        cos_q30,
	output q30_t        sin_q30
);
	localparam int N = (STAGES > TBL_LEN) ? TBL_LEN : STAGES;

	// square root of the scaled gain product, worked out at elaboration
	function automatic longint unsigned gain_root();
		longint unsigned p, n, r, b;
		p = 64'd1 << 60;
		for (int i = 0; i < N; i++) p = p + (p >> (2 * i));
		n = p; r = 0; b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b); r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// start value 2^60/G, G the gain scaled by 2^30
	localparam longint unsigned G  = gain_root();
	localparam longint          X0 = longint'(((64'd1 << 60) + (G >> 1)) / G);

	logic signed [33:0] x_q [N+1];
	logic signed [33:0] y_q [N+1];
	logic signed [32:0] z_q [N+1];
	logic               f_q [N+1];
	logic               v_q [N+1];

	logic [31:0] ang32;
	logic        flip;
	logic [31:0] a_rot;

	assign ang32 = {angle, 16'd0};
	assign flip  = (ang32[31:30] == 2'd1) || (ang32[31:30] == 2'd2);
	assign a_rot = flip ? ang32 - 32'h80000000 : ang32;

	always_comb begin
		x_q[0] = 34'(X0);
		y_q[0] = '0;
		z_q[0] = 33'(signed'(a_rot));
		f_q[0] = flip;
		v_q[0] = in_vld;
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else begin
				v_q[i+1] <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			f_q[i+1] <= f_q[i];
			if (!z_q[i][32]) begin
				x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] - 33'(ATAN_TAB[i]);
			end else begin
				x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] + 33'(ATAN_TAB[i]);
			end
		end
	end

	// pad to the fixed latency the caller expects
	localparam int PAD = LAT - N;
	logic signed [33:0] xp [PAD+1];
	logic signed [33:0] yp [PAD+1];
	logic               fp [PAD+1];
	logic               vp [PAD+1];
	always_comb begin
		xp[0] = x_q[N]; yp[0] = y_q[N]; fp[0] = f_q[N]; vp[0] = v_q[N];
	end
	for (genvar j = 0; j < PAD; j++) begin : g_pad
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vp[j+1] <= 1'b0;
			end else begin
				vp[j+1] <= vp[j];
			end
		end
		always_ff @(posedge clk) begin
			xp[j+1] <= xp[j]; yp[j+1] <= yp[j]; fp[j+1] <= fp[j];
		end
	end

	logic signed [33:0] xc, yc;
	assign xc = fp[PAD] ? -xp[PAD] : xp[PAD];
	assign yc = fp[PAD] ? -yp[PAD] : yp[PAD];
	assign cos_q30 = xc[31:0];
	assign sin_q30 = yc[31:0];
	assign out_vld = vp[PAD];
endmodule

>>> src/aarm_norm.sv
// aarm_norm: pipelined normalization of the axis, restoring square root and dividers
// depends on aarm_pkg

module aarm_norm import aarm_pkg::*; #(
	parameter int LAT = 66
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic signed [15:0] ax,
	input  logic signed [15:0] ay,
	input  logic signed [15:0] az,
	input  logic signed [15:0] aw,
	output logic               out_vld,
	output logic               zero,
	output q30_t               ux,
	output q30_t               uy,
	output q30_t               uz
);
	// stage 1: squares and sum
	logic [SUM_W-1:0] sum_s1;
	logic             v_s1;
	logic [15:0]      mag_s1 [3];
	logic             neg_s1 [3];
	logic signed [15:0] comp [3];
	assign comp[0] = ax; assign comp[1] = ay; assign comp[2] = az;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
		end
	end
	always_ff @(posedge clk) begin
		sum_s1 <= SUM_W'(32'(ax * ax)) + SUM_W'(32'(ay * ay))
			+ SUM_W'(32'(az * az)) + SUM_W'(32'(aw * aw));
		for (int k = 0; k < 3; k++) begin
			neg_s1[k] <= comp[k][15];
			mag_s1[k] <= comp[k][15] ? 16'(-comp[k]) : comp[k];
		end
	end

	// stage 2: scale by 4^sh to at least 2^60
	logic [4:0]  sh;
	logic [63:0] t_s2;
	logic [4:0]  sh_s2;
	logic        v_s2, z_s2;
	logic [15:0] mag_s2 [3];
	logic        neg_s2 [3];
	always_comb begin
		// highest nonzero bit pair of the sum sets the shift
		sh = 5'd0;
		for (int b = 0; b <= 16; b++) begin
			if (sum_s1[2*b +: 2] != 2'd0) sh = 5'(30 - b);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		z_s2  <= (sum_s1 == '0);
		sh_s2 <= sh;
		t_s2  <= 64'(sum_s1) << (2 * sh);
		mag_s2 <= mag_s1; neg_s2 <= neg_s1;
	end

	// square root: one result bit per stage, 31 stages
	logic [63:0] rn [ROOT_W+1];
	logic [63:0] rr [ROOT_W+1];
	logic        rv [ROOT_W+1];
	logic        rz [ROOT_W+1];
	logic [4:0]  rsh [ROOT_W+1];
	logic [15:0] rmag [ROOT_W+1][3];
	logic        rneg [ROOT_W+1][3];
	always_comb begin
		rn[0] = t_s2; rr[0] = '0; rv[0] = v_s2; rz[0] = z_s2; rsh[0] = sh_s2;
		rmag[0] = mag_s2; rneg[0] = neg_s2;
	end
	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		// scaled sum is below 2^62, so the first trial bit is 2^60
		localparam logic [63:0] BIT = 64'd1 << (60 - 2 * i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv[i+1] <= 1'b0;
			end else begin
				rv[i+1] <= rv[i];
			end
		end
		always_ff @(posedge clk) begin
			if (rn[i] >= rr[i] + BIT) begin
				rn[i+1] <= rn[i] - (rr[i] + BIT);
				rr[i+1] <= (rr[i] >> 1) + BIT;
			end else begin
				rn[i+1] <= rn[i];
				rr[i+1] <= rr[i] >> 1;
			end
			rz[i+1] <= rz[i]; rsh[i+1] <= rsh[i];
			rmag[i+1] <= rmag[i]; rneg[i+1] <= rneg[i];
		end
	end

	// division: num = mag << (30+sh) + root/2, quotient bits one per stage
	logic [ROOT_W-1:0] root;
	assign root = rr[ROOT_W][ROOT_W-1:0];
	localparam int NUM_W = 16 + 30 + 16 + 1;
	logic [NUM_W-1:0]  dn  [QUO_W+1][3];
	logic [QUO_W-1:0]  dq  [QUO_W+1][3];
	logic [ROOT_W-1:0] dd  [QUO_W+1];
	logic              dv  [QUO_W+1];
	logic              dz  [QUO_W+1];
	logic              dneg [QUO_W+1][3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dn[0][k] = (NUM_W'(rmag[ROOT_W][k]) << (30 + rsh[ROOT_W]))
				+ NUM_W'(root >> 1);
			dq[0][k] = '0;
		end
		dd[0] = root; dv[0] = rv[ROOT_W]; dz[0] = rz[ROOT_W]; dneg[0] = rneg[ROOT_W];
	end
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		localparam int P = QUO_W - 1 - i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[i+1] <= 1'b0;
			end else begin
				dv[i+1] <= dv[i];
			end
		end
		always_ff @(posedge clk) begin
			for (int k = 0; k < 3; k++) begin
				if (dn[i][k] >= (NUM_W'(dd[i]) << P)) begin
					dn[i+1][k] <= dn[i][k] - (NUM_W'(dd[i]) << P);
					dq[i+1][k] <= dq[i][k] | (QUO_W'(1) << P);
				end else begin
					dn[i+1][k] <= dn[i][k];
					dq[i+1][k] <= dq[i][k];
				end
			end
			dd[i+1] <= dd[i]; dz[i+1] <= dz[i]; dneg[i+1] <= dneg[i];
		end
	end

	// pad the output after the front stages, the root and the dividers up to LAT
	localparam int PAD = LAT - (2 + ROOT_W + QUO_W);
	q30_t pu [PAD+1][3];
	logic pv [PAD+1];
	logic pz [PAD+1];
	always_comb begin
		for (int k = 0; k < 3; k++)
			pu[0][k] = dneg[QUO_W][k] ? -q30_t'(dq[QUO_W][k]) : q30_t'(dq[QUO_W][k]);
		pv[0] = dv[QUO_W]; pz[0] = dz[QUO_W];
	end
	for (genvar j = 0; j < PAD; j++) begin : g_pad
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv[j+1] <= 1'b0;
			end else begin
				pv[j+1] <= pv[j];
			end
		end
		always_ff @(posedge clk) begin
			pu[j+1] <= pu[j]; pz[j+1] <= pz[j];
		end
	end

	assign out_vld = pv[PAD];
	assign zero    = pz[PAD];
	assign ux      = pu[PAD][0];
	assign uy      = pu[PAD][1];
	assign uz      = pu[PAD][2];
endmodule

>>> src/aarm_matrix.sv
// aarm_matrix: pipelined rodrigues combination of unit axis, sine and cosine
// depends on aarm_pkg

module aarm_matrix import aarm_pkg::*; #(
	parameter int FRAC = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic        zero,
	input  q30_t        ux,
	input  q30_t        uy,
	input  q30_t        uz,
	input  q30_t        c,
	input  q30_t        s,
	output logic        out_vld,
	output logic [15:0] m [9],
	output logic        zero_o
);
	// stage 1: products of unit components, products with sine, (1-c) and scaled cosine
	logic signed [63:0] pp_s1 [9];
	logic signed [63:0] ls_s1 [3];
	logic signed [32:0] omc_s1;
	logic signed [63:0] cd_s1;
	logic               v_s1, z_s1;
	q30_t u [3];
	assign u[0] = ux; assign u[1] = uy; assign u[2] = uz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
		end
	end
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) pp_s1[r*3+k] <= 64'(u[r]) * 64'(u[k]);
			ls_s1[r] <= 64'(u[r]) * 64'(s);
		end
		omc_s1 <= 33'sd1073741824 - 33'(c);
		cd_s1  <= 64'(c) <<< 30;
		z_s1   <= zero;
	end

	// stage 2: round to q.30 then multiply by (1-c)
	logic signed [63:0] w_s2 [9];
	logic signed [63:0] ls_s2 [3];
	logic signed [63:0] cd_s2;
	logic               v_s2, z_s2;
	logic signed [31:0] rnd [9];
	always_comb begin
		for (int k = 0; k < 9; k++) rnd[k] = 32'((pp_s1[k] + 64'sd536870912) >>> 30);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) w_s2[k] <= 64'(rnd[k]) * 64'(omc_s1);
		ls_s2 <= ls_s1; cd_s2 <= cd_s1; z_s2 <= z_s1;
	end

	// stage 3: add diagonal or cross term, round and clamp; a zero axis gives the identity
	localparam longint LIM = 64'sd1 << FRAC;
	localparam int     SH  = 60 - FRAC;
	logic signed [63:0] sum [9];
	logic signed [63:0] rv  [9];
	logic [15:0]        o   [9];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (r == k)
					sum[r*3+k] = w_s2[r*3+k] + cd_s2;
				else if ((r == 0 && k == 2) || (r == 1 && k == 0) || (r == 2 && k == 1))
					sum[r*3+k] = w_s2[r*3+k] + ls_s2[3-r-k];
				else
					sum[r*3+k] = w_s2[r*3+k] - ls_s2[3-r-k];
			end
		end
		for (int k = 0; k < 9; k++) begin
			rv[k] = (sum[k] + (64'sd1 <<< (SH - 1))) >>> SH;
			if (z_s2) rv[k] = (k == 0 || k == 4 || k == 8) ? LIM : 64'sd0;
			if (rv[k] > LIM) rv[k] = LIM;
			if (rv[k] < -LIM) rv[k] = -LIM;
			if (rv[k] > 64'sd32767) rv[k] = 64'sd32767;
			if (rv[k] < -64'sd32768) rv[k] = -64'sd32768;
			o[k] = rv[k][15:0];
		end
	end
	logic v_s3, z_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		m    <= o;
		z_s3 <= z_s2;
	end
	assign out_vld = v_s3;
	assign zero_o  = z_s3;
endmodule

>>> src/axis_angle_rotation_matrix_unit.sv
// axis_angle_rotation_matrix_unit: top level, rodrigues rotation matrix from axis and angle
// depends on aarm_pkg, aarm_norm, aarm_cordic, aarm_matrix

// Rotation matrix unit. Pulse start with an axis (x, y, z, w) and a 16-bit binary
// angle; busy is never raised, so a transaction can be started in every cycle.
// The axis is normalized by its four-component length through a pipelined square
// root (31 stages) and three pipelined dividers (32 stages); sine and cosine come
// from a CORDIC pipeline running alongside. The matrix stages follow, and each
// result is marked by done for exactly one cycle. The receiver cannot stall:
// results must be taken as they come. An all-zero axis raises zero_axis and
// gives the identity.
module axis_angle_rotation_matrix_unit import aarm_pkg::*; #(
	parameter int OUT_FRAC_BITS = 14,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [15:0] axis_w,
	input  logic [15:0]        turn_angle,
	output logic               done,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic               zero_axis
);
	// normalization latency sets the front end; cordic is padded to match
	localparam int NORM_LAT = 2 + ROOT_W + QUO_W;

	logic nv, cv, zr;
	q30_t ux, uy, uz, cs, sn;
	logic [15:0] mo [9];

	assign busy = 1'b0;

	aarm_norm #(.LAT(NORM_LAT)) u_norm (
		.clk, .arst_n, .in_vld(start),
		.ax(axis_x), .ay(axis_y), .az(axis_z), .aw(axis_w),
		.out_vld(nv), .zero(zr), .ux, .uy, .uz
	);

	aarm_cordic #(.STAGES(CORDIC_STAGES), .LAT(NORM_LAT)) u_cordic (
		.clk, .arst_n, .in_vld(start), .angle(turn_angle),
		.out_vld(cv), .cos_q30(cs), .sin_q30(sn)
	);

	// both branches are aligned, so one valid drives the matrix stage
	aarm_matrix #(.FRAC(OUT_FRAC_BITS)) u_matrix (
		.clk, .arst_n, .in_vld(nv & cv), .zero(zr),
		.ux, .uy, .uz, .c(cs), .s(sn),
		.out_vld(done), .m(mo), .zero_o(zero_axis)
	);

	assign m00 = mo[0]; assign m01 = mo[1]; assign m02 = mo[2];
	assign m10 = mo[3]; assign m11 = mo[4]; assign m12 = mo[5];
	assign m20 = mo[6]; assign m21 = mo[7]; assign m22 = mo[8];
endmodule

>>> dv/tb_axis_angle_rotation_matrix_unit.sv
// tb_axis_angle_rotation_matrix_unit: self-checking testbench for the rotation matrix unit
// predicts each untyped matrix in integer q.30 arithmetic and compares each done strobe in order
// depends on aarm_pkg and axis_angle_rotation_matrix_unit
`timescale 1ns / 1ps

module tb_axis_angle_rotation_matrix_unit import aarm_pkg::*; ();

	localparam int OUT_FRAC_BITS = 14;
	localparam int CORDIC_STAGES = 16;
	localparam int HALF_PERIOD   = 6;
	localparam int RANDOM_ITEMS  = 1550;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 150;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	typedef struct {
		logic signed [15:0] m [9];
		logic               zero;
	} matrix_t;

	typedef struct {
		logic signed [15:0] ax, ay, az, aw;
		logic [15:0]        ang;
		bit                 typed;   // expected matrix given in the row itself
		matrix_t            mat;
	} axis_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0, axis_w = '0;
	logic [15:0]        turn_angle = '0;
	logic               done;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic               zero_axis;

	// row typing travels with the inputs so the acceptance edge sees a matching pair
	logic               row_typed = 1'b0;
	matrix_t            row_mat;

	matrix_t            pending_matrices[$];
	axis_item_t         directed_rows[$];
	int                 mismatch_count = 0;
	int                 quiet_cycles = 0;
	int                 idle_pct = 0;

	axis_angle_rotation_matrix_unit #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .axis_w(axis_w),
		.turn_angle(turn_angle), .done(done),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22), .zero_axis(zero_axis)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// bitwise integer square root, floor
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// rotation-mode cordic on a 32-bit binary angle, results in q.30
	function automatic void cordic_sin_cos(input logic [15:0] ang, output longint c,
			output longint s);
		logic [31:0]     full, a;
		bit              flip;
		longint          z, x, y, dx, dy;
		longint unsigned p, g;
		full = {ang, 16'h0000};
		// second and third quadrants are turned by half a circle first
		flip = (full[31:30] == 2'b01) || (full[31:30] == 2'b10);
		a = flip ? full - 32'h8000_0000 : full;
		z = {{32{a[31]}}, a};
		p = 64'd1 << 60;
		for (int i = 0; i < CORDIC_STAGES && i < TBL_LEN; i++)
			p += p >> (2 * i);
		g = int_sqrt(p);
		x = longint'(((64'd1 << 60) + g / 2) / g);
		y = 0;
		for (int i = 0; i < CORDIC_STAGES && i < TBL_LEN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// q.60 sum down to the output format, clamped to plus or minus one
	function automatic logic signed [15:0] q60_to_entry(longint v);
		longint r, lim;
		lim = 64'sd1 <<< OUT_FRAC_BITS;
		r = round_shift(v, 60 - OUT_FRAC_BITS);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic matrix_t predict_rotation(logic signed [15:0] ax, ay, az, aw,
			logic [15:0] ang);
		matrix_t         res;
		longint          a [4];
		longint          u [3];
		longint unsigned sum, t, root, mag, num;
		longint          q, c, s, omc, v, lin;
		int              sh, other;
		a[0] = ax; a[1] = ay; a[2] = az; a[3] = aw;
		sum = 0;
		for (int k = 0; k < 4; k++) sum += longint'(a[k] * a[k]);
		if (sum == 0) begin
			// zero axis gives the identity whatever the angle
			for (int k = 0; k < 9; k++)
				res.m[k] = q60_to_entry((k % 4 == 0) ? (64'sd1 <<< 60) : 64'sd0);
			res.zero = 1'b1;
			return res;
		end
		t = sum;
		sh = 0;
		while (t < (64'd1 << 60)) begin
			t <<= 2;
			sh++;
		end
		root = int_sqrt(t);
		for (int k = 0; k < 3; k++) begin
			mag = (a[k] < 0) ? -a[k] : a[k];
			num = mag << (30 + sh);
			q = longint'((num + root / 2) / root);
			u[k] = (a[k] < 0) ? -q : q;
		end
		cordic_sin_cos(ang, c, s);
		omc = (64'sd1 <<< 30) - c;
		for (int r = 0; r < 3; r++) begin
			for (int col = 0; col < 3; col++) begin
				v = round_shift(u[r] * u[col], 30) * omc;
				if (r == col) begin
					v += c * (64'sd1 <<< 30);
				end else begin
					// cross-product term is positive below the diagonal wrap
					other = 3 - r - col;
					lin = u[other] * s;
					v += (col == (r + 2) % 3) ? lin : -lin;
				end
				res.m[r * 3 + col] = q60_to_entry(v);
			end
		end
		res.zero = 1'b0;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// acceptance and result side, both sampled at the rising edge
	always @(posedge clk) begin
		matrix_t            want;
		logic signed [15:0] got [9];
		if (start && !busy && arst_n) begin
			if (row_typed)
				pending_matrices.push_back(row_mat);
			else
				pending_matrices.push_back(predict_rotation(axis_x, axis_y, axis_z,
					axis_w, turn_angle));
		end
		if (done && arst_n) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			if (pending_matrices.size() == 0) begin
				report_mismatch("unexpected transaction, pending count", 0, 0);
			end else begin
				want = pending_matrices.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== want.m[k])
						report_mismatch($sformatf("m%0d%0d", k / 3, k % 3), got[k], want.m[k]);
				if (zero_axis !== want.zero)
					report_mismatch("zero_axis", zero_axis, want.zero);
			end
		end
	end

	// watchdog: no transaction in either direction for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	task automatic add_row(int ax, ay, az, aw, logic [15:0] ang,
			bit typed = 1'b0);
		axis_item_t row;
		row.ax = 16'(ax); row.ay = 16'(ay); row.az = 16'(az); row.aw = 16'(aw);
		row.ang = ang;
		row.typed = typed;
		row.mat.m = '{ONE_Q14, 16'sd0, 16'sd0, 16'sd0, ONE_Q14, 16'sd0, 16'sd0, 16'sd0,
			ONE_Q14};
		row.mat.zero = 1'b1;
		directed_rows.push_back(row);
	endtask

	// one transaction: optional idle gap, then hold start until busy is low
	task automatic send_item(axis_item_t it);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		axis_x     <= it.ax;
		axis_y     <= it.ay;
		axis_z     <= it.az;
		axis_w     <= it.aw;
		turn_angle <= it.ang;
		row_typed  <= it.typed;
		row_mat    <= it.mat;
		do @(posedge clk); while (busy);
	endtask

	function automatic axis_item_t random_item();
		axis_item_t it;
		int         kind;
		it.typed = 1'b0;
		it.ang = 16'($urandom);
		kind = $urandom_range(99);
		it.ax = 16'($urandom); it.ay = 16'($urandom);
		it.az = 16'($urandom); it.aw = 16'($urandom);
		if (kind < 5) begin
			// all-zero axis now and then
			it.ax = '0; it.ay = '0; it.az = '0; it.aw = '0;
		end else if (kind < 15) begin
			// norm carried by w alone
			it.ax = '0; it.ay = '0; it.az = '0;
		end else if (kind < 30) begin
			// short axes exercise the normalizing shift
			it.ax = $signed(16'($urandom_range(0, 15))) - 16'sd8;
			it.ay = $signed(16'($urandom_range(0, 15))) - 16'sd8;
			it.az = $signed(16'($urandom_range(0, 15))) - 16'sd8;
			it.aw = $urandom_range(0, 1) ? 16'sd0 : it.aw >>> 12;
		end else if (kind < 40) begin
			it.ang = 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 16'd1);
		end
		return it;
	endfunction

	initial begin
		axis_item_t it;
		// zero axis rows, identity typed in
		add_row(0, 0, 0, 0, 16'h0000, 1'b1);
		add_row(0, 0, 0, 0, 16'hFFFF, 1'b1);
		add_row(0, 0, 0, 0, 16'h8000, 1'b1);
		// single-component axes, mostly at the quadrant boundaries
		add_row(1, 0, 0, 0, 16'h0000);
		add_row(0, 1, 0, 0, 16'h4000);
		add_row(0, 0, 1, 0, 16'h8000);
		add_row(0, 0, -1, 0, 16'hC000);
		add_row(0, 0, 0, 1, 16'h2000);
		add_row(0, 0, 0, -32768, 16'h3FFF);
		// field extremes
		add_row(-32768, -32768, -32768, -32768, 16'hFFFF);
		add_row(32767, 32767, 32767, 32767, 16'h7FFF);
		add_row(-32768, 32767, -32768, 32767, 16'hBFFF);
		add_row(32767, -32768, 0, 0, 16'h8001);
		add_row(-1, -1, -1, -1, 16'h0001);
		add_row(1, -1, 1, -1, 16'h5555);
		add_row(21845, -10922, 5461, 0, 16'hAAAA);
		add_row(0, 0, 32767, -32768, 16'hC001);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) send_item(directed_rows[i]);

		// random part in idling phases: none, heavy, none, light
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ((n * 4) / RANDOM_ITEMS)
				0: idle_pct = 0;
				1: idle_pct = 49;
				2: idle_pct = 0;
				default: idle_pct = 20;
			endcase
			it = random_item();
			send_item(it);
		end
		start <= 1'b0;

		while (pending_matrices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
